FILE: rtl/stt_pkg.sv
// shared types and constants of the source text tokenizer
package stt_pkg;

   // request and response payloads
   typedef struct packed {
      logic       command;
      logic [7:0] char_code;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] value;
      logic        ident_last;
      logic        ident_truncated;
      logic        number_saturated;
      logic        last;
   } rsp_type;

   // commands
   localparam logic CMD_CHAR = 1'b0;
   localparam logic CMD_END  = 1'b1;

   // token kinds
   localparam logic [2:0] KIND_CHAR = 3'd0;
   localparam logic [2:0] KIND_EQ   = 3'd1;
   localparam logic [2:0] KIND_NEQ  = 3'd2;
   localparam logic [2:0] KIND_GTE  = 3'd3;
   localparam logic [2:0] KIND_LTE  = 3'd4;
   localparam logic [2:0] KIND_NUM  = 3'd5;
   localparam logic [2:0] KIND_IDCH = 3'd6;
   localparam logic [2:0] KIND_END  = 3'd7;

   // character constants
   localparam logic [7:0] CH_EQUAL = 8'h3D;
   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_ZERO  = 8'h30;

   // character classes found by the front end
   typedef enum logic [2:0] {
      CLS_SPACE,
      CLS_ALPHA,
      CLS_DIGIT,
      CLS_OP,
      CLS_OTHER
   } char_class_type;

   // classified request held in the queue
   typedef struct packed {
      logic           is_end;
      char_class_type cls;
      logic [7:0]     code;
   } item_type;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

endpackage

FILE: rtl/stt_front.sv
// front end: accepts requests and classifies the character
module stt_front
   import stt_pkg::*;
(
   input  logic     req_push,
   input  req_type  req_data,
   output logic     req_full,
   input  logic     q_full,
   output logic     q_push,
   output item_type q_data
);

   logic [7:0] c;

   assign c        = req_data.char_code;
   assign req_full = q_full;
   assign q_push   = req_push && !q_full;

   always_comb begin
      q_data.is_end = (req_data.command == CMD_END);
      q_data.code   = c;
      if (c == 8'd32 || (c >= 8'd9 && c <= 8'd13)) begin
         q_data.cls = CLS_SPACE;
      end else if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) begin
         q_data.cls = CLS_ALPHA;
      end else if (c >= CH_ZERO && c <= 8'h39) begin
         q_data.cls = CLS_DIGIT;
      end else if (c == CH_EQUAL || c == CH_BANG || c == CH_LT || c == CH_GT) begin
         q_data.cls = CLS_OP;
      end else begin
         q_data.cls = CLS_OTHER;
      end
   end

endmodule

FILE: rtl/stt_queue.sv
// short queue of classified items between front and back end
module stt_queue
   import stt_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_data,
   output logic     full,
   input  logic     pop,
   output logic     empty,
   output item_type head
);

   item_type               slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]      count_ff, count_in;
   logic                   do_push, do_pop;

   assign full    = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/stt_back.sv
// back end: scanner state, identifier buffer and response register
module stt_back
   import stt_pkg::*;
#(
   parameter int MAX_IDENT_LEN = 16
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     q_empty,
   input  item_type q_head,
   output logic     q_pop,
   output logic     rsp_empty,
   input  logic     rsp_pop,
   output rsp_type  rsp_data
);

   localparam int IDX_W = (MAX_IDENT_LEN > 1) ? $clog2(MAX_IDENT_LEN) : 1;
   localparam int LEN_W = $clog2(MAX_IDENT_LEN + 1);

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_NUM,
      MODE_IDENT,
      MODE_OP
   } mode_type;

   typedef enum logic {
      ST_RUN,
      ST_IDENT
   } state_type;

   state_type        state_ff, state_in;
   mode_type         mode_ff, mode_in;
   logic [7:0]       pend_ff, pend_in;
   logic [31:0]      acc_ff, acc_in;
   logic             sat_ff, sat_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic             ovf_ff, ovf_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             out_valid_ff, out_valid_in;
   rsp_type          out_data_ff, out_data_in;

   logic [7:0]       ident_mem [MAX_IDENT_LEN];
   logic [7:0]       rd_data_ff;
   logic [IDX_W-1:0] rd_addr;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [7:0]       wr_data;

   logic             out_free, emit, follow_emit, id_final;
   logic [35:0]      acc_next;
   logic [2:0]       op_kind;

   assign out_free    = !out_valid_ff || rsp_pop;
   assign follow_emit = q_head.is_end || (q_head.cls == CLS_OTHER);
   assign id_final    = ((LEN_W'(idx_ff) + LEN_W'(1)) == len_ff);
   assign acc_next    = {acc_ff, 3'b000} + {2'b00, acc_ff, 1'b0}
                      + {32'd0, q_head.code[3:0]};
   assign rsp_empty   = !out_valid_ff;
   assign rsp_data    = out_data_ff;

   always_comb begin
      if (pend_ff == CH_EQUAL) begin
         op_kind = KIND_EQ;
      end else if (pend_ff == CH_BANG) begin
         op_kind = KIND_NEQ;
      end else if (pend_ff == CH_GT) begin
         op_kind = KIND_GTE;
      end else begin
         op_kind = KIND_LTE;
      end
   end

   always_comb begin
      state_in    = state_ff;
      mode_in     = mode_ff;
      pend_in     = pend_ff;
      acc_in      = acc_ff;
      sat_in      = sat_ff;
      len_in      = len_ff;
      ovf_in      = ovf_ff;
      idx_in      = idx_ff;
      emit        = 1'b0;
      out_data_in = out_data_ff;
      q_pop       = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = '0;
      wr_data     = q_head.code;
      rd_addr     = '0;

      case (state_ff)
         ST_RUN: begin
            if (!q_empty && out_free) begin
               out_data_in = '0;
               case (mode_ff)
                  MODE_IDLE: begin
                     q_pop = 1'b1;
                     if (q_head.is_end) begin
                        emit             = 1'b1;
                        out_data_in.kind = KIND_END;
                        out_data_in.last = 1'b1;
                     end else begin
                        case (q_head.cls)
                           CLS_ALPHA: begin
                              mode_in = MODE_IDENT;
                              wr_en   = 1'b1;
                              len_in  = LEN_W'(1);
                              ovf_in  = 1'b0;
                           end
                           CLS_DIGIT: begin
                              mode_in = MODE_NUM;
                              acc_in  = {28'd0, q_head.code[3:0]};
                              sat_in  = 1'b0;
                           end
                           CLS_OP: begin
                              mode_in = MODE_OP;
                              pend_in = q_head.code;
                           end
                           CLS_OTHER: begin
                              emit              = 1'b1;
                              out_data_in.kind  = KIND_CHAR;
                              out_data_in.value = {24'd0, q_head.code};
                              out_data_in.last  = 1'b1;
                           end
                           default: begin
                              // whitespace: nothing to do
                           end
                        endcase
                     end
                  end
                  MODE_IDENT: begin
                     if (!q_head.is_end && q_head.cls == CLS_ALPHA) begin
                        q_pop = 1'b1;
                        if (len_ff < LEN_W'(MAX_IDENT_LEN)) begin
                           wr_en   = 1'b1;
                           wr_addr = IDX_W'(len_ff);
                           len_in  = len_ff + 1'b1;
                        end else begin
                           ovf_in = 1'b1;
                        end
                     end else begin
                        // flush the buffer, item stays at the queue head
                        state_in = ST_IDENT;
                        idx_in   = '0;
                     end
                  end
                  MODE_NUM: begin
                     if (!q_head.is_end && q_head.cls == CLS_DIGIT) begin
                        q_pop = 1'b1;
                        if (acc_next[35:32] != 4'd0) begin
                           acc_in = 32'hFFFF_FFFF;
                           sat_in = 1'b1;
                        end else begin
                           acc_in = acc_next[31:0];
                        end
                     end else begin
                        emit                         = 1'b1;
                        out_data_in.kind             = KIND_NUM;
                        out_data_in.value            = acc_ff;
                        out_data_in.number_saturated = sat_ff;
                        out_data_in.last             = !follow_emit;
                        mode_in                      = MODE_IDLE;
                     end
                  end
                  MODE_OP: begin
                     emit    = 1'b1;
                     mode_in = MODE_IDLE;
                     if (!q_head.is_end && q_head.code == CH_EQUAL) begin
                        q_pop            = 1'b1;
                        out_data_in.kind = op_kind;
                        out_data_in.last = 1'b1;
                     end else begin
                        out_data_in.kind  = KIND_CHAR;
                        out_data_in.value = {24'd0, pend_ff};
                        out_data_in.last  = !follow_emit;
                     end
                  end
                  default: begin
                     mode_in = MODE_IDLE;
                  end
               endcase
            end
         end
         ST_IDENT: begin
            rd_addr = idx_ff;
            if (out_free) begin
               emit                        = 1'b1;
               out_data_in                 = '0;
               out_data_in.kind            = KIND_IDCH;
               out_data_in.value           = {24'd0, rd_data_ff};
               out_data_in.ident_last      = id_final;
               out_data_in.ident_truncated = ovf_ff;
               out_data_in.last            = id_final && !follow_emit;
               if (id_final) begin
                  state_in = ST_RUN;
                  mode_in  = MODE_IDLE;
               end else begin
                  idx_in  = idx_ff + 1'b1;
                  rd_addr = idx_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase

      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         mode_ff      <= MODE_IDLE;
         pend_ff      <= '0;
         acc_ff       <= '0;
         sat_ff       <= 1'b0;
         len_ff       <= '0;
         ovf_ff       <= 1'b0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
         out_data_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         pend_ff      <= pend_in;
         acc_ff       <= acc_in;
         sat_ff       <= sat_in;
         len_ff       <= len_in;
         ovf_ff       <= ovf_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
         out_data_ff  <= out_data_in;
      end
   end

   // identifier buffer, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ident_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= ident_mem[rd_addr];
   end

endmodule

FILE: rtl/source_text_tokenizer.sv
// top level of the source text tokenizer
//
//   channel   ports                          direction   handshake
//   request   req_push req_full req_data     in          push & !full
//   response  rsp_pop rsp_empty rsp_data     out         pop & !empty
//
// a request goes through the classifier into a two-entry queue; the scanner
// takes it from the registered queue head
// requests that only extend a token or start one are consumed directly;
// a number flush, or an operator not completed by '=', emits the pending
// token, then reprocesses the character; an identifier flush starts the
// buffer read, sends the buffered characters out one by one, then reprocesses
// reset is synchronous and clears all control state; no clearing pass
// the scanner stalls while the response register is held; req_full rises
// when both queue entries are taken
module source_text_tokenizer
   import stt_pkg::*;
#(
   parameter int MAX_IDENT_LEN = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   input  req_type req_data,
   output logic    req_full,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   // queue between classifier and scanner
   logic     q_full;
   logic     q_push;
   item_type q_in;
   logic     q_empty;
   logic     q_pop;
   item_type q_head;

   // classify each request as it is accepted
   stt_front u_front (
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_data   (q_in)
   );

   stt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   // scanner with identifier buffer and response register
   stt_back #(
      .MAX_IDENT_LEN (MAX_IDENT_LEN)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: tb/source_text_tokenizer_checker.sv
// token predictor and response checker for the source text tokenizer
`timescale 1ns / 100ps

module source_text_tokenizer_checker
   import stt_pkg::*;
#(
   parameter int MAX_IDENT_LEN = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   input  logic    req_full,
   input  req_type req_data,
   input  logic    rsp_pop,
   input  logic    rsp_empty,
   input  rsp_type rsp_data,
   output int      error_count,
   output int      outstanding,
   output int      requests_seen,
   output int      tokens_checked,
   output int      truncated_idents,
   output int      saturated_numbers
);

   typedef enum logic [1:0] {
      SCAN_IDLE,
      SCAN_NUMBER,
      SCAN_IDENT,
      SCAN_OPERATOR
   } scan_mode_type;

   localparam logic [7:0] CH_UPPER_A = "A";
   localparam logic [7:0] CH_UPPER_Z = "Z";
   localparam logic [7:0] CH_LOWER_A = "a";
   localparam logic [7:0] CH_LOWER_Z = "z";
   localparam logic [7:0] CH_NINE    = "9";
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_SPACE   = 8'h20;

   scan_mode_type scan_mode;
   logic [7:0]    held_operator;
   logic [31:0]   number_value;
   logic          number_clipped;
   logic [7:0]    ident_chars [MAX_IDENT_LEN];
   int            ident_count;
   logic          ident_clipped;
   rsp_type       expected_tokens [$];
   rsp_type       new_tokens [$];

   function automatic char_class_type classify(logic [7:0] c);
      if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))
         return CLS_SPACE;
      if ((c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z))
         return CLS_ALPHA;
      if (c >= CH_ZERO && c <= CH_NINE)
         return CLS_DIGIT;
      if (c == CH_EQUAL || c == CH_BANG || c == CH_LT || c == CH_GT)
         return CLS_OP;
      return CLS_OTHER;
   endfunction

   task automatic report(string msg);
      $display("%0t ERROR: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic add_token(logic [2:0] kind, logic [31:0] value, logic id_last,
                            logic trunc, logic sat);
      rsp_type t;
      t.kind             = kind;
      t.value            = value;
      t.ident_last       = id_last;
      t.ident_truncated  = trunc;
      t.number_saturated = sat;
      t.last             = 1'b0;
      new_tokens.insert(new_tokens.size(), t);
   endtask

   // emit whatever token is being built and go back to idle
   task automatic flush_pending();
      case (scan_mode)
         SCAN_NUMBER: begin
            add_token(KIND_NUM, number_value, 1'b0, 1'b0, number_clipped);
            if (number_clipped)
               saturated_numbers++;
         end
         SCAN_IDENT: begin
            for (int i = 0; i < ident_count; i++)
               add_token(KIND_IDCH, {24'd0, ident_chars[i]}, i + 1 == ident_count,
                         ident_clipped, 1'b0);
            if (ident_clipped)
               truncated_idents++;
         end
         SCAN_OPERATOR:
            add_token(KIND_CHAR, {24'd0, held_operator}, 1'b0, 1'b0, 1'b0);
         default: ;
      endcase
      scan_mode = SCAN_IDLE;
   endtask

   task automatic tokenize_request(req_type r);
      char_class_type cls;
      logic [35:0]    wide;
      logic [2:0]     kind;
      rsp_type        t;
      new_tokens.delete();
      cls = classify(r.char_code);
      if (r.command == CMD_END) begin
         flush_pending();
         add_token(KIND_END, 32'd0, 1'b0, 1'b0, 1'b0);
      end else if (scan_mode == SCAN_IDENT && cls == CLS_ALPHA) begin
         if (ident_count < MAX_IDENT_LEN) begin
            ident_chars[ident_count] = r.char_code;
            ident_count++;
         end else begin
            ident_clipped = 1'b1;
         end
      end else if (scan_mode == SCAN_NUMBER && cls == CLS_DIGIT) begin
         wide = {4'd0, number_value} * 36'd10 + 36'(r.char_code - CH_ZERO);
         if (wide > 36'hFFFF_FFFF) begin
            number_value   = '1;
            number_clipped = 1'b1;
         end else begin
            number_value = wide[31:0];
         end
      end else if (scan_mode == SCAN_OPERATOR && r.char_code == CH_EQUAL) begin
         case (held_operator)
            CH_EQUAL: kind = KIND_EQ;
            CH_BANG:  kind = KIND_NEQ;
            CH_GT:    kind = KIND_GTE;
            default:  kind = KIND_LTE;
         endcase
         add_token(kind, 32'd0, 1'b0, 1'b0, 1'b0);
         scan_mode = SCAN_IDLE;
      end else begin
         flush_pending();
         case (cls)
            CLS_ALPHA: begin
               scan_mode      = SCAN_IDENT;
               ident_chars[0] = r.char_code;
               ident_count    = 1;
               ident_clipped  = 1'b0;
            end
            CLS_DIGIT: begin
               scan_mode      = SCAN_NUMBER;
               number_value   = 32'(r.char_code - CH_ZERO);
               number_clipped = 1'b0;
            end
            CLS_OP: begin
               scan_mode     = SCAN_OPERATOR;
               held_operator = r.char_code;
            end
            CLS_OTHER:
               add_token(KIND_CHAR, {24'd0, r.char_code}, 1'b0, 1'b0, 1'b0);
            default: ;
         endcase
      end
      foreach (new_tokens[i]) begin
         t      = new_tokens[i];
         t.last = (i == new_tokens.size() - 1);
         expected_tokens.insert(expected_tokens.size(), t);
      end
   endtask

   task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
         report($sformatf("token %0d field %s: got 0x%0h, expected 0x%0h",
                          tokens_checked, name, got, want));
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         scan_mode      = SCAN_IDLE;
         held_operator  = 8'd0;
         number_value   = 32'd0;
         number_clipped = 1'b0;
         ident_count    = 0;
         ident_clipped  = 1'b0;
         expected_tokens.delete();
      end else begin
         if (req_push && !req_full) begin
            tokenize_request(req_data);
            requests_seen++;
         end
         if (rsp_pop && !rsp_empty) begin
            if (expected_tokens.size() == 0) begin
               report($sformatf("unexpected token kind %0d value 0x%0h",
                                rsp_data.kind, rsp_data.value));
            end else begin
               want = expected_tokens[0];
               expected_tokens.delete(0);
               check_field("kind", 32'(rsp_data.kind), 32'(want.kind));
               check_field("value", rsp_data.value, want.value);
               check_field("ident_last", 32'(rsp_data.ident_last),
                           32'(want.ident_last));
               check_field("ident_truncated", 32'(rsp_data.ident_truncated),
                           32'(want.ident_truncated));
               check_field("number_saturated", 32'(rsp_data.number_saturated),
                           32'(want.number_saturated));
               check_field("last", 32'(rsp_data.last), 32'(want.last));
               tokens_checked++;
            end
         end
      end
      outstanding = expected_tokens.size();
   end

endmodule

FILE: tb/source_text_tokenizer_tb.sv
// testbench top of the source text tokenizer: stimulus, response pacing and verdict
`timescale 1ns / 100ps

module source_text_tokenizer_tb;
   import stt_pkg::*;

   localparam int IDENT_LEN    = 16;
   localparam int DRAIN_CYCLES = 48;           // longest identifier flush plus queue slack
   localparam int CYCLE_LIMIT  = 400000;       // far beyond the slowest correct run
   localparam int RANDOM_ITEMS = 175;
   localparam int CALM_ITEMS   = 40;           // final stretch without any idling

   localparam logic [7:0] CH_UPPER_A = "A";
   localparam logic [7:0] CH_LOWER_A = "a";
   localparam logic [7:0] CH_LOWER_X = "x";
   localparam logic [7:0] CH_LOWER_Z = "z";
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_SPACE   = 8'h20;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_push;
   req_type req_data;
   logic    req_full;
   logic    rsp_empty;
   logic    rsp_pop;
   rsp_type rsp_data;

   int error_count;
   int outstanding;
   int requests_seen;
   int tokens_checked;
   int truncated_idents;
   int saturated_numbers;

   bit          calm = 1'b0;                  // no idling on either side once set
   int          counted_items = 0;           // non-blank requests and ends, counted toward the random budget
   int unsigned cycle_count = 0;

   source_text_tokenizer #(
      .MAX_IDENT_LEN(IDENT_LEN)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   // watches both channels, predicts every token and compares
   source_text_tokenizer_checker #(
      .MAX_IDENT_LEN(IDENT_LEN)
   ) checker_inst (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_data          (req_data),
      .rsp_pop           (rsp_pop),
      .rsp_empty         (rsp_empty),
      .rsp_data          (rsp_data),
      .error_count       (error_count),
      .outstanding       (outstanding),
      .requests_seen     (requests_seen),
      .tokens_checked    (tokens_checked),
      .truncated_idents  (truncated_idents),
      .saturated_numbers (saturated_numbers)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d tokens still expected",
                  cycle_count, outstanding);
         $display("source_text_tokenizer_tb failed");
         $finish;
      end
   end

   function automatic bit is_blank(logic [7:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
   endfunction

   function automatic logic [7:0] random_letter();
      if ($urandom_range(0, 1) == 0)
         return CH_UPPER_A + 8'($urandom_range(0, 25));
      return CH_LOWER_A + 8'($urandom_range(0, 25));
   endfunction

   function automatic logic [7:0] random_digit();
      return CH_ZERO + 8'($urandom_range(0, 9));
   endfunction

   // a byte that is no letter, digit, blank or operator, high bytes included
   function automatic logic [7:0] random_other();
      logic [7:0] c;
      do begin
         c = 8'($urandom_range(0, 255));
      end while (is_blank(c) || (c >= CH_ZERO && c <= CH_ZERO + 8'd9)
                 || (c >= CH_UPPER_A && c <= CH_UPPER_A + 8'd25)
                 || (c >= CH_LOWER_A && c <= CH_LOWER_Z)
                 || c == CH_EQUAL || c == CH_BANG || c == CH_LT || c == CH_GT);
      return c;
   endfunction

   // one request: optional idle burst first, then hold push until accepted
   task automatic send(logic command, logic [7:0] code);
      req_type r;
      r.command   = command;
      r.char_code = code;
      if (!calm && $urandom_range(0, 9) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_full) @(posedge clock);
      // blanks alone are not counted toward the random budget
      if (command == CMD_END || !is_blank(code))
         counted_items++;
   endtask

   // stop sending until every expected token is out, then let the scanner go quiet
   task automatic settle();
      req_push <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // one well-formed token with random content, or some noise
   task automatic send_random_token();
      int    pick;
      int    length;
      string digits;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         // identifier, now and then right at or past the buffer size
         case ($urandom_range(0, 7))
            0:       length = IDENT_LEN;
            1:       length = IDENT_LEN + 1;
            2:       length = $urandom_range(IDENT_LEN + 2, IDENT_LEN + 14);
            default: length = $urandom_range(1, 8);
         endcase
         repeat (length) send(CMD_CHAR, random_letter());
      end else if (pick < 50) begin
         // number: short, long enough to saturate, or right at the 32 bit limit
         case ($urandom_range(0, 9))
            0: begin
               digits = ($urandom_range(0, 1) == 0) ? "4294967295" : "4294967296";
               for (int i = 0; i < digits.len(); i++)
                  send(CMD_CHAR, digits[i]);
            end
            1, 2:    repeat ($urandom_range(10, 13)) send(CMD_CHAR, random_digit());
            default: repeat ($urandom_range(1, 6)) send(CMD_CHAR, random_digit());
         endcase
      end else if (pick < 65) begin
         // relational operator, completed with '=' about half the time
         case ($urandom_range(0, 3))
            0:       send(CMD_CHAR, CH_EQUAL);
            1:       send(CMD_CHAR, CH_BANG);
            2:       send(CMD_CHAR, CH_LT);
            default: send(CMD_CHAR, CH_GT);
         endcase
         if ($urandom_range(0, 1) == 0)
            send(CMD_CHAR, CH_EQUAL);
      end else if (pick < 75) begin
         send(CMD_CHAR, ($urandom_range(0, 5) == 0) ? CH_SPACE
                                                     : CH_TAB + 8'($urandom_range(0, 4)));
      end else if (pick < 85) begin
         send(CMD_CHAR, random_other());
      end else if (pick < 93) begin
         // raw noise byte
         send(CMD_CHAR, 8'($urandom_range(0, 255)));
      end else begin
         // end of input, char_code carries junk
         send(CMD_END, 8'($urandom_range(0, 255)));
      end
   endtask

   // response side: pop almost always, with random stall bursts until the calm stretch
   initial begin
      rsp_pop <= 1'b0;
      forever begin
         @(posedge clock);
         if (!calm && !reset && $urandom_range(0, 11) == 0) begin
            rsp_pop <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end
         rsp_pop <= 1'b1;
      end
   end

   // request side
   initial begin
      int random_goal;
      reset    <= 1'b1;
      req_push <= 1'b0;
      req_data <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: end on idle, extreme and high bytes, blank ends a token,
      // identifier, number with a leading zero, all four combined operators,
      // operator followed by a letter, end flushing an operator, blank after an operator
      send(CMD_END, 8'h00);
      send(CMD_CHAR, 8'h00);
      send(CMD_CHAR, 8'hFF);
      send(CMD_CHAR, 8'h80);
      send(CMD_CHAR, CH_TAB);
      send(CMD_CHAR, CH_UPPER_A);
      send(CMD_CHAR, CH_LOWER_Z);
      send(CMD_CHAR, CH_CR);
      send(CMD_CHAR, CH_ZERO);
      send(CMD_CHAR, CH_ZERO + 8'd9);
      send(CMD_CHAR, CH_EQUAL);
      send(CMD_CHAR, CH_EQUAL);
      send(CMD_CHAR, CH_BANG);
      send(CMD_CHAR, CH_EQUAL);
      send(CMD_CHAR, CH_LT);
      send(CMD_CHAR, CH_EQUAL);
      send(CMD_CHAR, CH_GT);
      send(CMD_CHAR, CH_EQUAL);
      send(CMD_CHAR, CH_GT);
      send(CMD_CHAR, CH_LOWER_X);
      send(CMD_CHAR, CH_BANG);
      send(CMD_END, 8'hFF);
      send(CMD_CHAR, CH_LT);
      send(CMD_CHAR, CH_SPACE);
      send(CMD_CHAR, CH_EQUAL);
      send(CMD_END, 8'h5A);

      // hold off until the directed part has fully drained
      settle();

      // random token streams, the last stretch with no idling at all
      random_goal = counted_items + RANDOM_ITEMS;
      while (counted_items < random_goal) begin
         if (counted_items >= random_goal - CALM_ITEMS)
            calm = 1'b1;
         send_random_token();
      end
      send(CMD_END, 8'h00);

      settle();
      $display("covered %0d requests and %0d checked tokens", requests_seen, tokens_checked);
      $display("including %0d truncated identifiers and %0d saturated numbers",
               truncated_idents, saturated_numbers);
      if (error_count == 0)
         $display("source_text_tokenizer_tb passed");
      else
         $display("source_text_tokenizer_tb failed");
      $finish;
   end

endmodule
